/* src/ccrc_pkg.sv */
`timescale 1ns / 1ps

package ccrc_pkg;

  localparam int MAX_CRC_WIDTH = 64;
  localparam int MIN_CRC_WIDTH = 8;
  localparam int CRC_W_BITS    = 7;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [CRC_W_BITS-1:0]    RST_CRC_WIDTH  = 7'd32;
  localparam logic [MAX_CRC_WIDTH-1:0] RST_POLYNOMIAL = 64'h0000_0000_04C1_1DB7;
  localparam logic [MAX_CRC_WIDTH-1:0] RST_INIT_VALUE = 64'h0000_0000_FFFF_FFFF;
  localparam logic [MAX_CRC_WIDTH-1:0] RST_FINAL_XOR  = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CRC_WIDTH      = 3'd0,
    REG_POLYNOMIAL     = 3'd1,
    REG_INIT_VALUE     = 3'd2,
    REG_REFLECT_INPUT  = 3'd3,
    REG_REFLECT_OUTPUT = 3'd4,
    REG_FINAL_XOR      = 3'd5
  } ccrc_reg_t;

  // Settings the byte unit needs; polynomial is left-aligned to bit 63
  typedef struct packed {
    logic                     reflect_in;
    logic [MAX_CRC_WIDTH-1:0] poly_al;
  } ccrc_step_cfg_t;

  // Left shift that aligns a W-bit value to the top of the word (64 - W)
  function automatic logic [CRC_W_BITS-1:0] width_shift(input logic [CRC_W_BITS-1:0] w);
    logic [CRC_W_BITS-1:0] e;
    e = w;
    if (e < CRC_W_BITS'(MIN_CRC_WIDTH)) e = CRC_W_BITS'(MIN_CRC_WIDTH);
    if (e > CRC_W_BITS'(MAX_CRC_WIDTH)) e = CRC_W_BITS'(MAX_CRC_WIDTH);
    return CRC_W_BITS'(MAX_CRC_WIDTH) - e;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = v[7-i];
    return r;
  endfunction

  function automatic logic [MAX_CRC_WIDTH-1:0] rev_word(input logic [MAX_CRC_WIDTH-1:0] v);
    logic [MAX_CRC_WIDTH-1:0] r;
    for (int i = 0; i < MAX_CRC_WIDTH; i++) r[i] = v[MAX_CRC_WIDTH-1-i];
    return r;
  endfunction

endpackage

/* src/configurable_crc_engine.sv */
`timescale 1ns / 1ps

// Configurable CRC engine (Rocksoft model, MSB-first). Takes one byte beat per
// clock on in_* unless the result stream stalls; a beat with in_tlast high closes
// the message, and its CRC passes through a capture register and then the
// reflect/final-XOR output register to out_*, while the remainder restarts from
// the initial value. The full 8-step byte fold is done combinationally against a
// left-aligned remainder register, so throughput is one beat per cycle for any
// width from 8 to 64 unless the result stream stalls.
// Configuration writes on cfg_* are always ready and restart the message in
// progress; write only while no message is in flight. Widths below 8 act as 8,
// above 64 as 64; bits of polynomial, init_value and final_xor above the width
// are ignored, and result bits above the width are zero.
module configurable_crc_engine (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,   // is_last
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] crc_value
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int W  = ccrc_pkg::MAX_CRC_WIDTH;
  localparam int WB = ccrc_pkg::CRC_W_BITS;

  // configuration registers
  logic [WB-1:0] crc_width_r, crc_width_nxt;
  logic [W-1:0]  poly_r, poly_nxt;
  logic [W-1:0]  init_r, init_nxt;
  logic          refl_in_r, refl_in_nxt;
  logic          refl_out_r, refl_out_nxt;
  logic [W-1:0]  fxor_r, fxor_nxt;

  // datapath registers
  logic [W-1:0]  rem_r, rem_nxt;       // remainder, left-aligned to bit 63
  logic          fin_valid_r, fin_valid_nxt;
  logic [W-1:0]  fin_r, fin_nxt;       // closing remainder, left-aligned
  logic          out_valid_r, out_valid_nxt;
  logic [W-1:0]  out_data_r, out_data_nxt;

  logic          cfg_wr, in_acc, out_adv, fin_adv;
  logic [WB-1:0] shift_cur, shift_new;
  logic [W-1:0]  mask_cur, rem_step, fin_sel;
  ccrc_pkg::ccrc_step_cfg_t step_cfg;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  // advance each stage when it is empty or its beat moves on
  assign out_adv   = ~out_valid_r | out_tready;
  assign fin_adv   = ~fin_valid_r | out_adv;
  assign in_tready = fin_adv;
  assign in_acc    = in_tvalid & in_tready;

  assign shift_cur = ccrc_pkg::width_shift(crc_width_r);
  assign shift_new = ccrc_pkg::width_shift(crc_width_nxt);
  assign mask_cur  = {W{1'b1}} >> shift_cur;

  // aligning shift drops polynomial bits above the width
  assign step_cfg.reflect_in = refl_in_r;
  assign step_cfg.poly_al    = poly_r << shift_cur;

  ccrc_byte_unit u_byte (
    .rem_in    (rem_r),
    .data_byte (in_tdata),
    .has_byte  (in_tuser),
    .step_cfg  (step_cfg),
    .rem_out   (rem_step)
  );

  // register writes; an index beyond the list only restarts the message
  always_comb begin
    crc_width_nxt = crc_width_r;
    poly_nxt      = poly_r;
    init_nxt      = init_r;
    refl_in_nxt   = refl_in_r;
    refl_out_nxt  = refl_out_r;
    fxor_nxt      = fxor_r;
    if (cfg_wr) begin
      case (ccrc_pkg::ccrc_reg_t'(cfg_index))
        ccrc_pkg::REG_CRC_WIDTH:      crc_width_nxt = cfg_data[WB-1:0];
        ccrc_pkg::REG_POLYNOMIAL:     poly_nxt      = cfg_data;
        ccrc_pkg::REG_INIT_VALUE:     init_nxt      = cfg_data;
        ccrc_pkg::REG_REFLECT_INPUT:  refl_in_nxt   = cfg_data[0];
        ccrc_pkg::REG_REFLECT_OUTPUT: refl_out_nxt  = cfg_data[0];
        ccrc_pkg::REG_FINAL_XOR:      fxor_nxt      = cfg_data;
        default: ;
      endcase
    end
  end

  // remainder: reload on a write (new settings) or after a closing beat
  always_comb begin
    rem_nxt = rem_r;
    if (cfg_wr) begin
      rem_nxt = init_nxt << shift_new;
    end else if (in_acc) begin
      rem_nxt = in_tlast ? (init_r << shift_cur) : rem_step;
    end
  end

  // capture stage: hold the closing remainder until the output stage is free
  always_comb begin
    fin_valid_nxt = fin_valid_r;
    fin_nxt       = fin_r;
    if (fin_adv) begin
      fin_valid_nxt = in_acc & in_tlast;
      fin_nxt       = rem_step;
    end
  end

  // Reversing the left-aligned word mirrors it across the width, since the
  // bits below the width are zero; otherwise shift it back down.
  assign fin_sel = refl_out_r ? ccrc_pkg::rev_word(fin_r) : (fin_r >> shift_cur);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_adv) begin
      out_valid_nxt = fin_valid_r;
      out_data_nxt  = (fin_sel ^ fxor_r) & mask_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_width_r <= ccrc_pkg::RST_CRC_WIDTH;
      poly_r      <= ccrc_pkg::RST_POLYNOMIAL;
      init_r      <= ccrc_pkg::RST_INIT_VALUE;
      refl_in_r   <= 1'b1;
      refl_out_r  <= 1'b1;
      fxor_r      <= ccrc_pkg::RST_FINAL_XOR;
      rem_r       <= ccrc_pkg::RST_INIT_VALUE << ccrc_pkg::width_shift(ccrc_pkg::RST_CRC_WIDTH);
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      crc_width_r <= crc_width_nxt;
      poly_r      <= poly_nxt;
      init_r      <= init_nxt;
      refl_in_r   <= refl_in_nxt;
      refl_out_r  <= refl_out_nxt;
      fxor_r      <= fxor_nxt;
      rem_r       <= rem_nxt;
      fin_valid_r <= fin_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r      <= fin_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // bits below the aligned width stay clear in the remainder
  a_rem_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r & ~(~{W{1'b0}} << shift_cur)) == {W{1'b0}})
    else $error("remainder has bits below the CRC width alignment");

  // a result never carries bits above the width
  a_out_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r & ~mask_cur) == {W{1'b0}}))
    else $error("result has bits above the CRC width");

  // a captured CRC waiting on a full output stage is not dropped
  a_fin_held: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_valid_r && !out_adv) |=> (fin_valid_r && $stable(fin_r)))
    else $error("captured CRC lost while the output stage stalled");

  // the capture stage only fills from a closing beat
  a_fin_source: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_adv && !(in_acc && in_tlast)) |=> !fin_valid_r)
    else $error("capture stage filled without a closing beat");

endmodule

/* src/ccrc_byte_unit.sv */
`timescale 1ns / 1ps

// Fold one byte into a left-aligned remainder: eight shift/XOR steps
module ccrc_byte_unit (
  input  logic [ccrc_pkg::MAX_CRC_WIDTH-1:0] rem_in,
  input  logic [7:0]                         data_byte,
  input  logic                               has_byte,
  input  ccrc_pkg::ccrc_step_cfg_t           step_cfg,
  output logic [ccrc_pkg::MAX_CRC_WIDTH-1:0] rem_out
);

  logic [7:0]                         byte_in;
  logic [ccrc_pkg::MAX_CRC_WIDTH-1:0] r;

  always_comb begin
    byte_in = step_cfg.reflect_in ? ccrc_pkg::rev8(data_byte) : data_byte;
    r = rem_in ^ {byte_in, {(ccrc_pkg::MAX_CRC_WIDTH-8){1'b0}}};
    for (int k = 0; k < 8; k++) begin
      if (r[ccrc_pkg::MAX_CRC_WIDTH-1]) begin
        r = (r << 1) ^ step_cfg.poly_al;
      end else begin
        r = r << 1;
      end
    end
    // hold the remainder on a beat that carries no byte
    rem_out = has_byte ? r : rem_in;
  end

endmodule

/* test/crc_checker.sv */
`timescale 1ns / 1ps

module crc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  logic [6:0]  width_reg;
  logic [63:0] poly_reg;
  logic [63:0] init_reg;
  logic [63:0] fxor_reg;
  logic        rin_reg;
  logic        rout_reg;
  logic [63:0] remainder;
  logic [63:0] crc_due[$];
  int          mismatches = 0;

  function automatic int live_width(input logic [6:0] w);
    if (w < 7'd8) return 8;
    if (w > 7'd64) return 64;
    return int'(w);
  endfunction

  function automatic logic [63:0] low_ones(input int w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [63:0] swap_order(input logic [63:0] v, input int n);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < n; i++) r[n-1-i] = v[i];
    return r;
  endfunction

  // one byte through the eight shift/xor steps, remainder kept right-aligned
  function automatic logic [63:0] absorb_byte(input logic [63:0] rem, input logic [7:0] b,
                                              input int w, input logic [63:0] poly,
                                              input logic rin);
    logic [63:0] m;
    logic [7:0]  v;
    logic        msb;
    m   = low_ones(w);
    v   = rin ? 8'(swap_order(64'(b), 8)) : b;
    rem = (rem ^ (64'(v) << (w - 8))) & m;
    for (int k = 0; k < 8; k++) begin
      msb = rem[w-1];
      rem = (rem << 1) & m;
      if (msb) rem = rem ^ (poly & m);
    end
    return rem;
  endfunction

  always @(posedge clk) begin : track
    int          w;
    logic [63:0] m;
    logic [63:0] want;
    if (!rst_n) begin
      width_reg = ccrc_pkg::RST_CRC_WIDTH;
      poly_reg  = ccrc_pkg::RST_POLYNOMIAL;
      init_reg  = ccrc_pkg::RST_INIT_VALUE;
      fxor_reg  = ccrc_pkg::RST_FINAL_XOR;
      rin_reg   = 1'b1;
      rout_reg  = 1'b1;
      remainder = ccrc_pkg::RST_INIT_VALUE & low_ones(live_width(ccrc_pkg::RST_CRC_WIDTH));
      crc_due.delete();
    end else begin
      w = live_width(width_reg);
      m = low_ones(w);
      if (out_tvalid && out_tready) begin
        if (crc_due.size() == 0) begin
          $display("%0t: crc result with none expected, expected none, actual %h",
                   $time, out_tdata);
          mismatches++;
        end else begin
          want = crc_due.pop_front();
          if (out_tdata !== want) begin
            $display("%0t: crc mismatch, expected %h, actual %h", $time, want, out_tdata);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser) remainder = absorb_byte(remainder, in_tdata, w, poly_reg, rin_reg);
        if (in_tlast) begin
          want = rout_reg ? swap_order(remainder & m, w) : (remainder & m);
          crc_due.push_back((want ^ fxor_reg) & m);
          remainder = init_reg & m;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ccrc_pkg::REG_CRC_WIDTH:      width_reg = cfg_data[6:0];
          ccrc_pkg::REG_POLYNOMIAL:     poly_reg  = cfg_data;
          ccrc_pkg::REG_INIT_VALUE:     init_reg  = cfg_data;
          ccrc_pkg::REG_REFLECT_INPUT:  rin_reg   = cfg_data[0];
          ccrc_pkg::REG_REFLECT_OUTPUT: rout_reg  = cfg_data[0];
          ccrc_pkg::REG_FINAL_XOR:      fxor_reg  = cfg_data;
          default: ;
        endcase
        remainder = init_reg & low_ones(live_width(width_reg));
      end
    end
    fail_count <= mismatches;
    pending    <= crc_due.size();
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  // register slots past the end of the map; a write there still restarts the message
  localparam logic [ccrc_pkg::CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [ccrc_pkg::CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  localparam int ITEMS_PER_SETTING = 75;
  localparam int SETTINGS_PER_LEG  = 6;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;   // [7:0] data_byte
  logic        in_tuser   = 1'b0;    // [0] has_byte
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;            // [63:0] crc_value
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = 3'd0;
  logic [63:0] cfg_data   = 64'd0;

  int fail_count;
  int pending;

  // percentage of cycles in which the sender holds off / the receiver stalls
  int send_idle = 25;
  int stall_pct = 75;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  configurable_crc_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  crc_checker crc_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver: stall the result stream at random, one decision per cycle.
  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  // Offer one input beat and hold it until the block takes it. Idle cycles
  // drop tvalid first; with no idle the previous beat's tvalid simply stays high.
  task automatic send_beat(input logic [7:0] b, input logic has, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= has;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop sending and wait until every CRC owed has come out, then let
  // `tail` more cycles pass so nothing is left inside the pipeline.
  task automatic drain(input int tail);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // One register write beat; cfg_valid stays high for a following write.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_word();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Reprogram the block. The first few settings are fixed corners (widths out
  // of range both ways, 8 and 64 bits, all-zero and all-ones words); the rest
  // are random and rewrite only a random subset of the registers.
  task automatic apply_settings(input int n);
    logic [63:0] w_val, p_val, i_val, ri_val, ro_val, x_val;
    logic        w_wr, p_wr, i_wr, ri_wr, ro_wr, x_wr, spare_wr;
    // upper bits of narrow registers carry noise; the block must ignore them
    w_val  = {$urandom, $urandom};
    ri_val = {$urandom, $urandom};
    ro_val = {$urandom, $urandom};
    p_val  = pick_word();
    i_val  = pick_word();
    x_val  = pick_word();
    {w_wr, p_wr, i_wr, ri_wr, ro_wr, x_wr} = '1;
    spare_wr = 1'b1;
    case (n)
      0: begin
        w_val[6:0] = 7'd0;
        p_val = '1; i_val = '1; x_val = '1;
        ri_val[0] = 1'b0; ro_val[0] = 1'b0;
      end
      1: begin
        w_val[6:0] = 7'd127;
        p_val = '0; i_val = '0; x_val = '0;
        ri_val[0] = 1'b1; ro_val[0] = 1'b1;
      end
      2: begin
        w_val[6:0] = 7'd64;
        p_val = 64'h42F0_E1EB_A9EA_3693; i_val = '1;
        ri_val[0] = 1'b0; ro_val[0] = 1'b1;
      end
      3: begin
        w_val[6:0] = 7'd8;
        p_val = 64'hFFFF_FFFF_FFFF_FF07; i_val = '0; x_val = '0;
        ri_val[0] = 1'b1; ro_val[0] = 1'b0;
      end
      default: begin
        case ($urandom_range(5))
          0:       w_val[6:0] = 7'($urandom_range(7));
          1:       w_val[6:0] = 7'($urandom_range(127, 65));
          2:       w_val[6:0] = 7'd8;
          3:       w_val[6:0] = 7'd64;
          default: w_val[6:0] = 7'($urandom_range(63, 9));
        endcase
        w_wr = ($urandom_range(9) < 6); p_wr  = ($urandom_range(9) < 6);
        i_wr = ($urandom_range(9) < 6); ri_wr = ($urandom_range(9) < 6);
        ro_wr = ($urandom_range(9) < 6); x_wr = ($urandom_range(9) < 6);
        spare_wr = ($urandom_range(4) == 0);
      end
    endcase
    if (!(w_wr | p_wr | i_wr | ri_wr | ro_wr | x_wr)) w_wr = 1'b1;
    if (w_wr)  write_reg(ccrc_pkg::REG_CRC_WIDTH, w_val);
    if (p_wr)  write_reg(ccrc_pkg::REG_POLYNOMIAL, p_val);
    if (i_wr)  write_reg(ccrc_pkg::REG_INIT_VALUE, i_val);
    if (ri_wr) write_reg(ccrc_pkg::REG_REFLECT_INPUT, ri_val);
    if (ro_wr) write_reg(ccrc_pkg::REG_REFLECT_OUTPUT, ro_val);
    if (x_wr)  write_reg(ccrc_pkg::REG_FINAL_XOR, x_val);
    if (spare_wr) write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random messages: mostly short, now and then long, with idle beats mixed
  // in and a mix of closing beats with and without a byte. Idle beats do not
  // count. Once per call hold the sender until the results have drained, and
  // sometimes leave a message open so the next configuration write drops it.
  task automatic random_messages(input int n);
    int  counted;
    int  len;
    int  hold_at;
    bit  held;
    counted = 0;
    held    = 1'b0;
    hold_at = $urandom_range(n - 1);
    while (counted < n) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
        send_beat(8'($urandom), 1'b1, 1'b0);
        counted++;
      end
      send_beat(8'($urandom), ($urandom_range(3) != 0), 1'b1);
      counted++;
      if (!held && counted >= hold_at) begin
        drain(0);
        held = 1'b1;
      end
    end
    if ($urandom_range(1) == 1)
      repeat ($urandom_range(1, 4)) send_beat(8'($urandom), 1'b1, 1'b0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset settings (reflected 32-bit CRC).
    // Standard check string "123456789", closing on its last byte.
    for (int i = 0; i < 9; i++) send_beat(8'h31 + 8'(i), 1'b1, (i == 8));
    // Empty message: close with no byte at all.
    send_beat(8'hFF, 1'b0, 1'b1);
    // Idle beat with a busy data field, then a zero byte closing.
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    // All-ones byte, an idle beat, then a bare close.
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h5A, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hA5, 1'b1, 1'b1);
    send_beat(8'h80, 1'b1, 1'b0);
    send_beat(8'h01, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b1);
    // Two empty messages back to back.
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h00, 1'b0, 1'b1);

    // Three legs of idling: sender light / receiver heavy, the reverse, none.
    for (int leg = 0; leg < 3; leg++) begin
      case (leg)
        0:       begin send_idle = 25; stall_pct = 75; end
        1:       begin send_idle = 75; stall_pct = 25; end
        default: begin send_idle = 0;  stall_pct = 0;  end
      endcase
      for (int s = 0; s < SETTINGS_PER_LEG; s++) begin
        drain(4);
        apply_settings(leg * SETTINGS_PER_LEG + s);
        random_messages(ITEMS_PER_SETTING);
      end
    end

    drain(8);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
